// File: rtl/core/heading_error_to_waypoint_defines.svh
// ----------------------------------------------------------------------------
// Heading error to waypoint: assertion macros
// Shared property wrappers, clocked on clk_i and masked while in reset.
// ----------------------------------------------------------------------------
`ifndef HEADING_ERROR_TO_WAYPOINT_DEFINES_SVH
`define HEADING_ERROR_TO_WAYPOINT_DEFINES_SVH

// Implication checked at every edge out of reset
`define HETW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every edge out of reset
`define HETW_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

// File: rtl/core/hetw_pkg.sv
// ----------------------------------------------------------------------------
// Heading error to waypoint: package
// Widths, angle constants, arctangent table and the side-band beat type.
// ----------------------------------------------------------------------------
package hetw_pkg;

  localparam int unsigned COORD_BITS_DEF    = 24;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned GUARD_BITS        = 8;
  // headroom for sign, pre-negation and CORDIC gain
  localparam int unsigned GROW_BITS         = 3;

  localparam int unsigned HEAD_W = 16;
  localparam int unsigned TURN_W = 16;

  // angle accumulator in 2^-16 degree
  localparam int unsigned Z_W         = 27;
  localparam int unsigned ROUND_SHIFT = 9;
  localparam int unsigned BEAR_W      = Z_W - 1 - ROUND_SHIFT;
  localparam int unsigned DIFF_W      = HEAD_W + 2;

  localparam int unsigned FULL_TURN = 46080;
  localparam int unsigned HALF_TURN = 23040;
  localparam int unsigned Z_HALF    = 180 * 65536;
  localparam int unsigned Z_BIAS    = 360 * 65536 + 256;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              here;
  } side_t;

  // round(atan(2^-i) * 65536), degrees
  function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = Z_W'(2949120);
      1:       v = Z_W'(1740967);
      2:       v = Z_W'(919879);
      3:       v = Z_W'(466945);
      4:       v = Z_W'(234379);
      5:       v = Z_W'(117304);
      6:       v = Z_W'(58666);
      7:       v = Z_W'(29335);
      8:       v = Z_W'(14668);
      9:       v = Z_W'(7334);
      10:      v = Z_W'(3667);
      11:      v = Z_W'(1833);
      12:      v = Z_W'(917);
      13:      v = Z_W'(458);
      14:      v = Z_W'(229);
      15:      v = Z_W'(115);
      16:      v = Z_W'(57);
      17:      v = Z_W'(29);
      18:      v = Z_W'(14);
      19:      v = Z_W'(7);
      20:      v = Z_W'(4);
      21:      v = Z_W'(2);
      22:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/hetw_if.sv
// ----------------------------------------------------------------------------
// Heading error to waypoint: channel interfaces
// Valid/ready channels for the offset beat and the turn beat.
// ----------------------------------------------------------------------------
interface hetw_in_if #(
  parameter int unsigned COORD_BITS = hetw_pkg::COORD_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic        [hetw_pkg::HEAD_W-1:0] heading;
  logic signed [COORD_BITS-1:0]     east_offset;
  logic signed [COORD_BITS-1:0]     north_offset;

  modport source (output valid, heading, east_offset, north_offset, input ready);
  modport sink   (input valid, heading, east_offset, north_offset, output ready);
endinterface

interface hetw_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hetw_pkg::TURN_W-1:0] turn_angle;
  logic                               target_here;

  modport source (output valid, turn_angle, target_here, input ready);
  modport sink   (input valid, turn_angle, target_here, output ready);
endinterface

// File: rtl/core/hetw_cordic_cell.sv
// ----------------------------------------------------------------------------
// Heading error to waypoint: CORDIC cell
// One vectoring micro-rotation with its own valid/ready stage register.
// ----------------------------------------------------------------------------
module hetw_cordic_cell #(
  parameter int unsigned W     = 35,
  parameter int unsigned STAGE = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [W-1:0]            x_i,
  input  logic signed [W-1:0]            y_i,
  input  logic signed [hetw_pkg::Z_W-1:0] z_i,
  input  hetw_pkg::side_t                side_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic signed [hetw_pkg::Z_W-1:0] z_o,
  output hetw_pkg::side_t                side_o
);

  localparam logic signed [hetw_pkg::Z_W-1:0] ANG = hetw_pkg::atan_lut(STAGE);

  logic                            valid_q;
  logic signed [W-1:0]             x_q, x_d, y_q, y_d, xs, ys;
  logic signed [hetw_pkg::Z_W-1:0] z_q, z_d;
  hetw_pkg::side_t                 side_q;
  logic                            load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  // turn clockwise while the east part is not negative
  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANG;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/hetw_wrap.sv
// ----------------------------------------------------------------------------
// Heading error to waypoint: angle wrap
// Rounds the bearing to 1/128 degree and folds bearing minus heading
// into the half-open range -180..+180 degrees, over two register stages.
// ----------------------------------------------------------------------------
module hetw_wrap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [hetw_pkg::Z_W-1:0]  z_i,
  input  hetw_pkg::side_t                  side_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [hetw_pkg::TURN_W-1:0] turn_o,
  output logic                             here_o
);

  localparam int unsigned ZW = hetw_pkg::Z_W;
  localparam int unsigned BW = hetw_pkg::BEAR_W;
  localparam int unsigned HW = hetw_pkg::HEAD_W;
  localparam int unsigned DW = hetw_pkg::DIFF_W;
  localparam int unsigned TW = hetw_pkg::TURN_W;

  localparam logic signed [ZW-1:0] BIAS   = ZW'(hetw_pkg::Z_BIAS);
  localparam logic        [BW-1:0] FULL_B = BW'(hetw_pkg::FULL_TURN);
  localparam logic        [HW-1:0] FULL_H = HW'(hetw_pkg::FULL_TURN);
  localparam logic signed [DW-1:0] FULL_D = DW'(hetw_pkg::FULL_TURN);
  localparam logic signed [DW-1:0] HALF_D = DW'(hetw_pkg::HALF_TURN);

  // stage A: bearing and heading reduced into one turn
  logic              a_valid_q, a_ready;
  logic signed [ZW-1:0] zp;
  logic [BW-1:0]     bq, bear_full;
  logic [HW-1:0]     bear_d, bear_q, head_d, head_q;
  logic              a_here_q;

  // stage B: turn beat
  logic                 b_valid_q, b_ready;
  logic signed [DW-1:0] diff, wrapped;
  logic signed [TW-1:0] turn_d, turn_q;
  logic                 b_here_q;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // bias keeps the sum positive, so the shift is a plain floor
  assign zp        = z_i + BIAS;
  assign bq        = zp[ZW-2:hetw_pkg::ROUND_SHIFT];
  assign bear_full = (bq >= FULL_B) ? bq - FULL_B : bq;
  assign bear_d    = bear_full[HW-1:0];
  assign head_d    = (side_i.heading >= FULL_H) ? side_i.heading - FULL_H : side_i.heading;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      bear_q   <= bear_d;
      head_q   <= head_d;
      a_here_q <= side_i.here;
    end
  end

  assign diff = $signed({2'b00, bear_q}) - $signed({2'b00, head_q});

  always_comb begin
    if (diff <= -HALF_D) begin
      wrapped = diff + FULL_D;
    end else if (diff > HALF_D) begin
      wrapped = diff - FULL_D;
    end else begin
      wrapped = diff;
    end
  end

  assign turn_d = a_here_q ? '0 : wrapped[TW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      turn_q   <= turn_d;
      b_here_q <= a_here_q;
    end
  end

  assign valid_o = b_valid_q;
  assign turn_o  = turn_q;
  assign here_o  = b_here_q;

endmodule

// File: rtl/core/heading_error_to_waypoint.sv
// Pipeline: offset beat -> pre-rotation register -> CORDIC cell registers -> wrap A, B.
// Throughput: one beat per cycle while the turn beat is taken; each CORDIC cell and
// the wrap stages hold their own valid flag, so bubbles close up behind a stalled turn beat.
// Reset: rst_ni clears every valid flag asynchronously; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// Heading error to waypoint
// Bearing of the waypoint by a chain of CORDIC vectoring cells, then the
// signed turn from the compass heading, wrapped to -180..+180 degrees.
// ----------------------------------------------------------------------------
`include "heading_error_to_waypoint_defines.svh"

module heading_error_to_waypoint #(
  parameter int unsigned COORD_BITS    = hetw_pkg::COORD_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = hetw_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hetw_in_if.sink     in_i,
  hetw_out_if.source  out_o
);

  localparam int unsigned GB = hetw_pkg::GUARD_BITS;
  localparam int unsigned CW = COORD_BITS + GB + hetw_pkg::GROW_BITS;
  localparam int unsigned ZW = hetw_pkg::Z_W;
  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned TW = hetw_pkg::TURN_W;

  localparam logic signed [TW-1:0] TURN_HI = TW'(hetw_pkg::HALF_TURN);
  localparam logic signed [TW-1:0] TURN_LO = TW'(1) - TURN_HI;

  logic                 cvalid [0:N];
  logic                 cready [0:N];
  logic signed [CW-1:0] cx     [0:N];
  logic signed [CW-1:0] cy     [0:N];
  logic signed [ZW-1:0] cz     [0:N];
  hetw_pkg::side_t      cside  [0:N];

  // pre-rotation stage: scale, fold the southern half plane
  logic signed [CW-1:0] east_sc, north_sc, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  hetw_pkg::side_t      side_d, side_q;
  logic                 pre_valid_q, pre_ready, south;

  logic                 out_here, turn_zero, turn_in_range;

  assign east_sc  = {{hetw_pkg::GROW_BITS{in_i.east_offset[COORD_BITS-1]}},
                     in_i.east_offset, {GB{1'b0}}};
  assign north_sc = {{hetw_pkg::GROW_BITS{in_i.north_offset[COORD_BITS-1]}},
                     in_i.north_offset, {GB{1'b0}}};
  assign south    = in_i.north_offset[COORD_BITS-1];

  assign x_d = south ? -north_sc : north_sc;
  assign y_d = south ? -east_sc : east_sc;
  assign z_d = south ? ZW'(hetw_pkg::Z_HALF) : '0;

  assign side_d.heading = in_i.heading;
  assign side_d.here    = (in_i.east_offset == '0) && (in_i.north_offset == '0);

  assign pre_ready  = !pre_valid_q || cready[0];
  assign in_i.ready = pre_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (pre_ready) begin
      pre_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && pre_ready) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_d;
    end
  end

  assign cvalid[0] = pre_valid_q;
  assign cx[0]     = x_q;
  assign cy[0]     = y_q;
  assign cz[0]     = z_q;
  assign cside[0]  = side_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    hetw_cordic_cell #(
      .W     (CW),
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cvalid[k]),
      .ready_o (cready[k]),
      .x_i     (cx[k]),
      .y_i     (cy[k]),
      .z_i     (cz[k]),
      .side_i  (cside[k]),
      .valid_o (cvalid[k+1]),
      .ready_i (cready[k+1]),
      .x_o     (cx[k+1]),
      .y_o     (cy[k+1]),
      .z_o     (cz[k+1]),
      .side_o  (cside[k+1])
    );
  end

  hetw_wrap u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cvalid[N]),
    .ready_o (cready[N]),
    .z_i     (cz[N]),
    .side_i  (cside[N]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .turn_o  (out_o.turn_angle),
    .here_o  (out_o.target_here)
  );

  assign out_here      = out_o.valid && out_o.target_here;
  assign turn_zero     = (out_o.turn_angle == '0);
  assign turn_in_range = (out_o.turn_angle <= TURN_HI) && (out_o.turn_angle >= TURN_LO);

  // an empty output register must leave the whole chain open to a new beat
  `HETW_ASSERT_ALW(a_ready_open, (out_o.valid || in_i.ready), "input stalled with empty output")
  `HETW_ASSERT_IMP(a_here_zero, out_here, turn_zero, "target_here with non-zero turn")
  `HETW_ASSERT_IMP(a_turn_range, out_o.valid, turn_in_range, "turn angle outside half turn")

endmodule
